[rtl/sdq_pkg.sv]
// Shared types and constants for the sorted deadline queue.
// Used by sdq_ctrl, sdq_datapath and sorted_deadline_queue_top.
`default_nettype none

package sdq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned TIME_W        = 48;
  localparam int unsigned KIND_W        = 2;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_EXPIRED  = 2'd2
  } kind_t;

  // one stored entry
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] dl;
  } entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic  capture;   // latch the incoming transaction, load insert cursor
    logic  rd_req;    // read one slot into the read register
    logic  rd_head;   // read the head slot, else the slot left of the cursor
    logic  shift;     // move the read entry one slot toward the tail
    logic  place;     // write the new entry at the cursor, occupancy + 1
    logic  pop;       // drop the head, keep it as pending result
    logic  out_load;  // load the output register
    logic  out_pend;  // output source: pending entry, else the request
    kind_t out_kind;
    logic  out_last;
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic p_zero;    // insert cursor at the head
    logic rd_gt;     // read deadline greater than the request key
    logic out_free;  // output register can take a new result
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/sdq_datapath.sv]
// Datapath of the sorted deadline queue: circular entry memory, head,
// occupancy, insert cursor, request and pending registers, output register.
// Depends on sdq_pkg.
`default_nettype none

module sdq_datapath #(
  parameter int unsigned DEPTH = sdq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      mode,
  input  wire logic [sdq_pkg::TAG_W-1:0]  entry_tag,
  input  wire logic [sdq_pkg::TIME_W-1:0] deadline,
  input  wire logic [sdq_pkg::TIME_W-1:0] now_time,
  input  wire sdq_pkg::ctl_cmd_t         cmd,
  output sdq_pkg::dp_stat_t              stat,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [sdq_pkg::KIND_W-1:0]     kind,
  output logic [sdq_pkg::TAG_W-1:0]      out_tag,
  output logic [sdq_pkg::TIME_W-1:0]     out_deadline,
  output logic                           last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // logical index to physical slot, relative to the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                         input logic [CW-1:0] idx);
    logic [AW:0] s;
    s = {1'b0, hd} + (AW+1)'(idx);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  sdq_pkg::entry_t mem [DEPTH];

  logic [AW-1:0]              head;
  logic [CW-1:0]              cnt;
  logic [CW-1:0]              p;
  logic [sdq_pkg::TAG_W-1:0]  req_tag;
  logic [sdq_pkg::TIME_W-1:0] key;
  sdq_pkg::entry_t            rd_q;
  sdq_pkg::entry_t            pend;
  sdq_pkg::entry_t            req_entry;
  sdq_pkg::entry_t            out_src;
  logic [CW-1:0]              rd_log;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic                       out_free;

  assign req_entry = '{tag: req_tag, dl: key};
  assign rd_log    = cmd.rd_head ? '0 : p - 1'b1;
  assign rd_addr   = phys(head, rd_log);
  assign wr_addr   = phys(head, p);
  assign out_free  = !out_valid || !out_stall;

  // status
  always_comb begin
    stat.full     = (cnt == CW'(DEPTH));
    stat.empty    = (cnt == '0);
    stat.p_zero   = (p == '0);
    stat.rd_gt    = (rd_q.dl > key);
    stat.out_free = out_free;
  end

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.shift || cmd.place) begin
      mem[wr_addr] <= cmd.shift ? rd_q : req_entry;
    end
    if (cmd.rd_req) begin
      rd_q <= mem[rd_addr];
    end
  end

  // request capture and pending expired entry
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_tag <= entry_tag;
      key     <= mode ? now_time : deadline;
    end
    if (cmd.pop) begin
      pend <= rd_q;
    end
  end

  // head, occupancy and insert cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
      p    <= '0;
    end else begin
      if (cmd.capture) begin
        p <= cnt;
      end else if (cmd.shift) begin
        p <= p - 1'b1;
      end
      if (cmd.place) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.pop) begin
        cnt <= cnt - 1'b1;
      end
      if (cmd.pop) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
    end
  end

  // output register
  assign out_src = cmd.out_pend ? pend : req_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind         <= cmd.out_kind;
      out_tag      <= out_src.tag;
      out_deadline <= out_src.dl;
      last         <= cmd.out_last;
    end
  end

  // checks on command usage
  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> cnt != '0)
    else $error("pop on empty queue");

  a_place_not_full : assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> cnt < CW'(DEPTH))
    else $error("place on full queue");

  a_load_free : assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("output overwritten while held");

  a_pop_count : assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> cnt == $past(cnt) - 1'b1)
    else $error("occupancy not reduced by pop");

endmodule

`default_nettype wire

[rtl/sdq_ctrl.sv]
// Controller of the sorted deadline queue: sequences insert scans and
// tick expiry, drives datapath commands. Depends on sdq_pkg.
`default_nettype none

module sdq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              mode,
  output logic                   in_stall,
  input  wire sdq_pkg::dp_stat_t stat,
  output sdq_pkg::ctl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_IN_RD,
    S_IN_CMP,
    S_IN_ACC,
    S_IN_FULL,
    S_TK_RD,
    S_TK_CMP,
    S_TK_END
  } state_t;

  state_t state, state_next;
  logic   has_pend, has_pend_next;

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    cmd           = '0;
    cmd.out_kind  = sdq_pkg::KIND_ACCEPTED;
    state_next    = state;
    has_pend_next = has_pend;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture   = 1'b1;
          has_pend_next = 1'b0;
          state_next    = mode ? S_TK_RD : S_IN_RD;
        end
      end
      // walk back from the tail, one slot per pass through S_IN_RD and S_IN_CMP
      S_IN_RD: begin
        if (stat.full) begin
          state_next = S_IN_FULL;
        end else if (stat.p_zero) begin
          cmd.place  = 1'b1;
          state_next = S_IN_ACC;
        end else begin
          cmd.rd_req = 1'b1;
          state_next = S_IN_CMP;
        end
      end
      S_IN_CMP: begin
        if (stat.rd_gt) begin
          cmd.shift  = 1'b1;
          state_next = S_IN_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_IN_ACC;
        end
      end
      S_IN_ACC: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = sdq_pkg::KIND_ACCEPTED;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_IN_FULL: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = sdq_pkg::KIND_FULL;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      // pop due heads; each is held until the next one is judged
      S_TK_RD: begin
        if (stat.empty) begin
          state_next = S_TK_END;
        end else begin
          cmd.rd_req  = 1'b1;
          cmd.rd_head = 1'b1;
          state_next  = S_TK_CMP;
        end
      end
      S_TK_CMP: begin
        if (stat.rd_gt) begin
          state_next = S_TK_END;
        end else if (!has_pend || stat.out_free) begin
          if (has_pend) begin
            cmd.out_load = 1'b1;
            cmd.out_pend = 1'b1;
            cmd.out_kind = sdq_pkg::KIND_EXPIRED;
          end
          cmd.pop       = 1'b1;
          has_pend_next = 1'b1;
          state_next    = S_TK_RD;
        end
      end
      S_TK_END: begin
        if (!has_pend) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_pend = 1'b1;
          cmd.out_kind = sdq_pkg::KIND_EXPIRED;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      has_pend <= 1'b0;
    end else begin
      state    <= state_next;
      has_pend <= has_pend_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sorted_deadline_queue_top.sv]
// Sorted deadline queue top level (controller plus datapath); uses sdq_pkg, sdq_ctrl, sdq_datapath.
// Insert: each stored entry with a later deadline is moved one slot toward the tail, then the new
//   entry is placed (result KIND_FULL if full); input is taken in the cycle the result appears.
// Tick: pops every due head (deadline not later than now_time), one KIND_EXPIRED result each,
//   last set on the final one; no result when nothing is due. Stalled output holds input.
// Synchronous reset empties the queue; slot contents are not cleared.
`default_nettype none

module sorted_deadline_queue_top #(
  parameter int unsigned DEPTH = sdq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       mode,
  input  wire logic [sdq_pkg::TAG_W-1:0]  entry_tag,
  input  wire logic [sdq_pkg::TIME_W-1:0] deadline,
  input  wire logic [sdq_pkg::TIME_W-1:0] now_time,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [sdq_pkg::KIND_W-1:0]      kind,
  output logic [sdq_pkg::TAG_W-1:0]       out_tag,
  output logic [sdq_pkg::TIME_W-1:0]      out_deadline,
  output logic                            last
);

  sdq_pkg::ctl_cmd_t cmd;
  sdq_pkg::dp_stat_t stat;

  sdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sdq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .entry_tag    (entry_tag),
    .deadline     (deadline),
    .now_time     (now_time),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_tag      (out_tag),
    .out_deadline (out_deadline),
    .last         (last)
  );

endmodule

`default_nettype wire
